// ===== rtl/core/rpn_pkg.sv =====
package rpn_pkg;

  // default number of operand stack entries
  localparam int STACK_DEPTH_DEF = 16;

  // iterations of the shift-add multiply and the restoring divide
  localparam int ALU_STEPS = 32;

  // ascii codes the decoder knows
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // result error codes
  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0,
    ERR_CHAR  = 3'd1,
    ERR_UNDER = 3'd2,
    ERR_DEPTH = 3'd3,
    ERR_DIV0  = 3'd4,
    ERR_OVER  = 3'd5
  } err_t;

  // operations of the shared arithmetic unit
  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } alu_op_t;

  // request from the sequencer to the arithmetic unit
  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

endpackage

// ===== rtl/core/rpn_if.sv =====
// character stream into the evaluator
interface rpn_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

// one result beat per expression
interface rpn_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic        [2:0]  error;

  modport source (output valid, output value, output error, input ready);
  modport sink (input valid, input value, input error, output ready);
endinterface

// ===== rtl/core/rpn_expression_evaluator_top.sv =====
// channel  modport  payload                         beat
// expr     sink     character[7:0], last            one ascii character
// result   source   value[31:0] signed, error[2:0]  one result per expression
//
// digits and spaces are taken in the idle state; +, -, * and / pass the stack
// read, execute and unit states; * and / run the 32 iterations of the shared
// adder in rpn_alu. a character marked last adds the final stack read and load.
// rst is synchronous; it empties the stack count and clears the sticky error.
// expr.ready is high only while the sequencer waits for a character; a held
// result stalls only the load after the next last character, not the characters before.
module rpn_expression_evaluator_top import rpn_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  rpn_char_if.sink     expr,
  rpn_result_if.source result
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_X,
    S_EXEC,
    S_ALU,
    S_FIN,
    S_LOAD
  } state_t;

  state_t         state;
  logic [DW-1:0]  depth;
  err_t           err;
  alu_op_t        op_q;
  logic           last_q;
  logic [31:0]    yreg;
  logic           out_valid;
  logic [31:0]    out_value;
  logic [2:0]     out_error;

  logic           is_digit;
  logic           is_op;
  logic           is_space;
  alu_op_t        char_op;
  logic [7:0]     digit;
  logic [DW-1:0]  depth_m1;
  logic [DW-1:0]  depth_m2;
  logic           div_zero;

  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [31:0]    wr_data;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic [31:0]    rd_data;
  alu_req_t       alu_req;
  logic           alu_done;
  logic [31:0]    alu_res;

  // character decode
  assign is_digit = (expr.character >= CH_ZERO) && (expr.character <= CH_NINE);
  assign is_op    = (expr.character == CH_PLUS) || (expr.character == CH_MINUS) ||
                    (expr.character == CH_STAR) || (expr.character == CH_SLASH);
  assign is_space = (expr.character == CH_SPACE);
  assign digit    = expr.character - CH_ZERO;

  always_comb begin
    unique case (expr.character)
      CH_PLUS:  char_op = OP_ADD;
      CH_MINUS: char_op = OP_SUB;
      CH_STAR:  char_op = OP_MUL;
      default:  char_op = OP_DIV;
    endcase
  end

  assign depth_m1 = depth - DW'(1);
  assign depth_m2 = depth - DW'(2);
  assign div_zero = (op_q == OP_DIV) && (yreg == '0);

  // stack port and unit start control
  always_comb begin
    wr_en         = 1'b0;
    wr_addr       = depth[AW-1:0];
    wr_data       = 32'(digit);
    rd_en         = 1'b0;
    rd_addr       = depth_m1[AW-1:0];
    alu_req.start = 1'b0;
    alu_req.op    = op_q;
    unique case (state)
      S_IDLE: begin
        if (expr.valid && (err == ERR_NONE)) begin
          if (is_digit && (depth != DW'(STACK_DEPTH))) begin
            wr_en = 1'b1;
          end
          if (is_op && (depth >= DW'(2))) begin
            rd_en = 1'b1;
          end
        end
      end
      S_RD_X: begin
        rd_en   = 1'b1;
        rd_addr = depth_m2[AW-1:0];
      end
      S_EXEC: begin
        alu_req.start = !div_zero;
      end
      S_ALU: begin
        if (alu_done) begin
          wr_en   = 1'b1;
          wr_addr = depth_m2[AW-1:0];
          wr_data = alu_res;
        end
      end
      S_FIN: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      default: begin
      end
    endcase
  end

  // sequencer, stack count, sticky error and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      depth     <= '0;
      err       <= ERR_NONE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && result.ready && (state != S_LOAD)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (expr.valid) begin
            last_q <= expr.last;
            op_q   <= char_op;
            state  <= expr.last ? S_FIN : S_IDLE;
            if (err == ERR_NONE) begin
              if (is_digit) begin
                if (depth == DW'(STACK_DEPTH)) begin
                  err <= ERR_OVER;
                end else begin
                  depth <= depth + DW'(1);
                end
              end else if (is_op) begin
                if (depth < DW'(2)) begin
                  err <= ERR_UNDER;
                end else begin
                  state <= S_RD_X;
                end
              end else if (!is_space) begin
                err <= ERR_CHAR;
              end
            end
          end
        end
        S_RD_X: begin
          yreg  <= rd_data;
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (div_zero) begin
            err   <= ERR_DIV0;
            state <= last_q ? S_FIN : S_IDLE;
          end else begin
            state <= S_ALU;
          end
        end
        S_ALU: begin
          if (alu_done) begin
            depth <= depth_m1;
            state <= last_q ? S_FIN : S_IDLE;
          end
        end
        S_FIN: begin
          if ((err == ERR_NONE) && (depth != DW'(1))) begin
            err <= ERR_DEPTH;
          end
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (!out_valid || result.ready) begin
            out_valid <= 1'b1;
            out_value <= (err == ERR_NONE) ? rd_data : '0;
            out_error <= err;
            depth     <= '0;
            err       <= ERR_NONE;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign expr.ready   = (state == S_IDLE);
  assign result.valid = out_valid;
  assign result.value = out_value;
  assign result.error = out_error;

  rpn_stack #(
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rpn_alu u_alu (
    .clk  (clk),
    .rst  (rst),
    .req  (alu_req),
    .x    (rd_data),
    .y    (yreg),
    .done (alu_done),
    .res  (alu_res)
  );

endmodule

// ===== rtl/core/rpn_stack.sv =====
module rpn_stack import rpn_pkg::*; #(
  parameter int DEPTH = STACK_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [31:0]              wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [31:0]              rd_data
);

  logic [31:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/rpn_alu.sv =====
module rpn_alu import rpn_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  alu_req_t    req,
  input  logic [31:0] x,
  input  logic [31:0] y,
  output logic        done,
  output logic [31:0] res
);

  localparam int STEP_W = $clog2(ALU_STEPS);

  typedef enum logic [2:0] {
    P_IDLE,
    P_ONE,
    P_ABSX,
    P_ABSY,
    P_LOOP,
    P_END
  } phase_t;

  phase_t              phase;
  alu_op_t             op_q;
  logic [31:0]         acc;
  logic [31:0]         opnd;
  logic [31:0]         shreg;
  logic [STEP_W-1:0]   count;
  logic                neg;

  logic [32:0] add_a;
  logic [32:0] add_b;
  logic        add_sub;
  logic [33:0] sum;
  logic        no_borrow;

  // operand select for the one shared adder
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (phase)
      P_ONE: begin
        add_a   = {1'b0, acc};
        add_b   = {1'b0, opnd};
        add_sub = (op_q == OP_SUB);
      end
      P_ABSX: begin
        add_b   = {1'b0, acc};
        add_sub = 1'b1;
      end
      P_ABSY: begin
        add_b   = {1'b0, opnd};
        add_sub = 1'b1;
      end
      P_LOOP: begin
        if (op_q == OP_DIV) begin
          // trial subtract of the divisor from the shifted remainder
          add_a   = {acc, shreg[31]};
          add_b   = {1'b0, opnd};
          add_sub = 1'b1;
        end else begin
          add_a = {1'b0, acc};
          add_b = {1'b0, opnd};
        end
      end
      P_END: begin
        add_b   = {1'b0, shreg};
        add_sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // carry out of a subtract is set when no borrow occurred
  assign sum       = {1'b0, add_a} + {1'b0, add_b ^ {33{add_sub}}} + 34'(add_sub);
  assign no_borrow = sum[33];

  // sequencer of the unit
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done  <= 1'b0;
    end else begin
      // result is loaded on the final phase of each operation
      done <= (phase == P_ONE) || (phase == P_END);
      unique case (phase)
        P_IDLE: begin
          if (req.start) begin
            op_q  <= req.op;
            count <= '0;
            neg   <= x[31] ^ y[31];
            case (req.op)
              OP_MUL: begin
                acc   <= '0;
                opnd  <= x;
                shreg <= y;
                phase <= P_LOOP;
              end
              OP_DIV: begin
                acc   <= x;
                opnd  <= y;
                phase <= P_ABSX;
              end
              default: begin
                acc   <= x;
                opnd  <= y;
                phase <= P_ONE;
              end
            endcase
          end
        end
        P_ONE: begin
          res   <= sum[31:0];
          phase <= P_IDLE;
        end
        P_ABSX: begin
          // magnitude of the dividend becomes the quotient shifter
          shreg <= acc[31] ? sum[31:0] : acc;
          acc   <= '0;
          phase <= P_ABSY;
        end
        P_ABSY: begin
          opnd  <= opnd[31] ? sum[31:0] : opnd;
          phase <= P_LOOP;
        end
        P_LOOP: begin
          if (op_q == OP_DIV) begin
            acc   <= no_borrow ? sum[31:0] : add_a[31:0];
            shreg <= {shreg[30:0], no_borrow};
          end else begin
            if (shreg[0]) begin
              acc <= sum[31:0];
            end
            opnd  <= {opnd[30:0], 1'b0};
            shreg <= {1'b0, shreg[31:1]};
          end
          count <= count + STEP_W'(1);
          if (count == STEP_W'(ALU_STEPS - 1)) begin
            phase <= P_END;
          end
        end
        P_END: begin
          if (op_q == OP_DIV) begin
            res <= neg ? sum[31:0] : shreg;
          end else begin
            res <= acc;
          end
          phase <= P_IDLE;
        end
        default: begin
          phase <= P_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/rpn_checker.sv =====
module rpn_checker import rpn_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_value,
  input logic [2:0]  out_error
);

  // a stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_error))
    else $error("result beat changed while stalled");

  // only defined error codes leave the block
  a_err_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_error <= ERR_OVER)
    else $error("undefined error code on result");

  // a failed expression reports a zero value
  a_err_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_error != ERR_NONE) |-> out_value == '0)
    else $error("nonzero value with error");

  // the final character is followed by the result load, not another character
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("ready right after last character");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind rpn_expression_evaluator_top rpn_checker u_rpn_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (expr.valid),
  .in_ready  (expr.ready),
  .in_last   (expr.last),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_value (result.value),
  .out_error (result.error)
);
